// ===== hw/rtl/ssl_pkg.sv =====
`timescale 1ns / 1ps
package ssl_pkg;
	localparam logic [9:0] EMPTY_MARK = 10'd999;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_IDLE   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2
	} act_t;

	typedef struct packed {
		act_t       act;
		logic [9:0] item_id;
		logic [3:0] position;
	} cell_cmd_t;
endpackage

// ===== hw/rtl/ssl_cell.sv =====
`timescale 1ns / 1ps
module ssl_cell import ssl_pkg::*; #(
	parameter int CELL_IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic       lower_gt,
	input  logic [9:0] lower_val,
	input  logic [9:0] upper_val,
	output logic       gt,
	output logic [9:0] val
);
	logic [9:0] val_q;
	logic       at_or_above;

	assign val         = val_q;
	assign gt          = val_q > cmd.item_id;
	assign at_or_above = 32'(cmd.position) <= CELL_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= EMPTY_MARK;
		end else begin
			case (cmd.act)
				ACT_INSERT: begin
					if (lower_gt) begin
						val_q <= lower_val;
					end else if (gt) begin
						val_q <= cmd.item_id;
					end
				end
				ACT_REMOVE: begin
					if (at_or_above) begin
						val_q <= upper_val;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/sorted_slot_list_top.sv =====
`timescale 1ns / 1ps
// sorted slot list: a row of cells holding identifiers in ascending order,
// empty slots read as 999 and sit above the used ones.
// input channel s_axis: one transaction is an operation (insert, remove or
// read) with an identifier and a slot position.
// output channel m_axis: one transaction per input transaction, carrying the
// accepted flag, the value at the position after the operation and the count.
// the cells update at the input transaction edge, the result register loads on
// the following edge and m_axis_tvalid rises at that same edge.
// a new operation is taken only once the result of the last one has been formed
// and taken; the forming step and the single result register set this.
// s_axis_tready stays low while a result is being formed or waits to be taken.
// when the receiver stalls the result holds steady and no new input is taken.
// reset clears the count, fills every slot with 999 and empties the output.
module sorted_slot_list_top import ssl_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // operation, item_id, position
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // accepted, read_value, item_count
);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic [1:0]       in_op;
	logic [9:0]       in_id;
	logic [3:0]       in_pos;
	logic             s_acc;
	logic             ins_ok;
	logic             rem_ok;
	logic             op_ok;
	cell_cmd_t        cmd;
	logic [CNT_W-1:0] count_q;
	logic             pend_q;
	logic             ok_s1;
	logic [3:0]       pos_s1;
	logic             out_valid_q;
	logic             acc_q;
	logic [9:0]       rd_q;
	logic [4:0]       cnt_out_q;
	logic [9:0]       rd_val;

	logic [9:0]       cell_val [SLOT_COUNT];
	logic             cell_gt  [SLOT_COUNT];

	assign in_op  = s_axis_tdata[1:0];
	assign in_id  = s_axis_tdata[11:2];
	assign in_pos = s_axis_tdata[15:12];

	assign s_axis_tready = !pend_q && !out_valid_q;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign ins_ok = (in_op == OP_INSERT) && (in_id < EMPTY_MARK)
		&& (count_q < CNT_W'(SLOT_COUNT));
	assign rem_ok = (in_op == OP_REMOVE) && (32'(in_pos) < 32'(count_q));
	assign op_ok  = ins_ok || rem_ok || (in_op == OP_READ);

	always_comb begin
		cmd.item_id  = in_id;
		cmd.position = in_pos;
		cmd.act      = ACT_IDLE;
		if (s_acc && ins_ok) begin
			cmd.act = ACT_INSERT;
		end else if (s_acc && rem_ok) begin
			cmd.act = ACT_REMOVE;
		end
	end

	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
		logic       lower_gt;
		logic [9:0] lower_val;
		logic [9:0] upper_val;
		if (k == 0) begin : g_first
			assign lower_gt  = 1'b0;
			assign lower_val = EMPTY_MARK;
		end else begin : g_mid
			assign lower_gt  = cell_gt[k-1];
			assign lower_val = cell_val[k-1];
		end
		if (k == SLOT_COUNT - 1) begin : g_last
			assign upper_val = EMPTY_MARK;
		end else begin : g_up
			assign upper_val = cell_val[k+1];
		end
		ssl_cell #(.CELL_IDX(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.lower_gt  (lower_gt),
			.lower_val (lower_val),
			.upper_val (upper_val),
			.gt        (cell_gt[k]),
			.val       (cell_val[k])
		);
	end

	assign rd_val = (32'(pos_s1) < SLOT_COUNT) ? cell_val[IDX_W'(pos_s1)] : EMPTY_MARK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				pend_q <= 1'b1;
				if (ins_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (rem_ok) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (pend_q) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ok_s1  <= op_ok;
			pos_s1 <= in_pos;
		end
		if (pend_q) begin
			acc_q     <= ok_s1;
			rd_q      <= rd_val;
			cnt_out_q <= 5'(count_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {cnt_out_q, rd_q, acc_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= SLOT_COUNT)
		else $error("item count beyond capacity");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && out_valid_q))
		else $error("pending work while a result waits");
	a_accept_pends: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> pend_q)
		else $error("transaction taken without forming a result");
	a_refused_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !ins_ok && !rem_ok |=> $stable(count_q))
		else $error("count changed on a refused operation");
`endif
endmodule

// ===== tb/sorted_slot_list_checker.sv =====
`timescale 1ns / 1ps
module sorted_slot_list_checker import ssl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] in_data,   // operation, item_id, position
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_data,  // accepted, read_value, item_count
	output int          errors,
	output int          pending
);
	localparam int SLOT_COUNT = 16;

	typedef struct packed {
		logic       accepted;
		logic [9:0] read_value;
		logic [4:0] item_count;
	} list_result_t;

	logic [9:0]   sorted_ids [SLOT_COUNT];
	int           used_slots;
	list_result_t pending_results [$];

	initial errors = 0;
	initial pending = 0;

	function automatic list_result_t apply_list_op(op_t op, logic [9:0] id, logic [3:0] pos);
		list_result_t res;
		int at;
		res.accepted = 1'b0;
		case (op)
			OP_INSERT: begin
				if (id < EMPTY_MARK && used_slots < SLOT_COUNT) begin
					at = used_slots;
					// lowest slot holding a larger id, so equal ids stay in arrival order
					for (int k = used_slots - 1; k >= 0; k--)
						if (sorted_ids[k] > id)
							at = k;
					for (int k = used_slots; k > at; k--)
						sorted_ids[k] = sorted_ids[k - 1];
					sorted_ids[at] = id;
					used_slots++;
					res.accepted = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (int'(pos) < used_slots) begin
					for (int k = pos; k < SLOT_COUNT - 1; k++)
						sorted_ids[k] = sorted_ids[k + 1];
					sorted_ids[SLOT_COUNT - 1] = EMPTY_MARK;
					used_slots--;
					res.accepted = 1'b1;
				end
			end
			OP_READ: res.accepted = 1'b1;
			default: res.accepted = 1'b0;
		endcase
		res.read_value = sorted_ids[pos];
		res.item_count = used_slots[4:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			for (int k = 0; k < SLOT_COUNT; k++)
				sorted_ids[k] = EMPTY_MARK;
			used_slots = 0;
			pending_results.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = list_result_t'({out_data[15:11], out_data[10:1], out_data[0]});
				got.accepted   = out_data[0];
				got.read_value = out_data[10:1];
				got.item_count = out_data[15:11];
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result %h with no transaction outstanding", $time, out_data);
				end else begin
					want = pending_results.pop_front();
					if (got.accepted !== want.accepted) begin
						errors++;
						$display("%0t: accepted expected %0d got %0d", $time,
							want.accepted, got.accepted);
					end
					if (got.read_value !== want.read_value) begin
						errors++;
						$display("%0t: read_value expected %0d got %0d", $time,
							want.read_value, got.read_value);
					end
					if (got.item_count !== want.item_count) begin
						errors++;
						$display("%0t: item_count expected %0d got %0d", $time,
							want.item_count, got.item_count);
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_list_op(op_t'(in_data[1:0]), in_data[11:2],
					in_data[15:12]));
			pending = pending_results.size();
		end
	end
endmodule

// ===== tb/tb_sorted_slot_list_top.sv =====
`timescale 1ns / 1ps
module tb_sorted_slot_list_top;
	import ssl_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_OPS = 1020;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	int          burst_left = 0;

	sorted_slot_list_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sorted_slot_list_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_tready),
		.out_data  (m_axis_tdata),
		.errors    (mismatches),
		.pending   (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] pack_op(op_t op, logic [9:0] id, logic [3:0] pos);
		return {pos, id, op};
	endfunction

	// offers one operation, with a random gap whenever a burst runs out
	task automatic offer(input logic [15:0] word);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		int r;
		int phase_left;
		bit filling;
		op_t op;
		logic [9:0] id;
		logic [3:0] pos;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, refused inserts, equal ids, refused removes
		offer(pack_op(OP_READ, 10'd0, 4'd0));
		offer(pack_op(OP_READ, 10'd1023, 4'd15));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd0));
		offer(pack_op(OP_NONE, 10'h2AA, 4'd5));
		offer(pack_op(OP_INSERT, 10'd999, 4'd0));
		offer(pack_op(OP_INSERT, 10'd1023, 4'd15));
		offer(pack_op(OP_INSERT, 10'd500, 4'd0));
		offer(pack_op(OP_INSERT, 10'd0, 4'd1));
		offer(pack_op(OP_INSERT, 10'd998, 4'd2));
		offer(pack_op(OP_INSERT, 10'd500, 4'd1));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd4));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd15));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd1));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd0));
		// fill to capacity, then overflow and work the top slot
		for (n = 0; n < 14; n++)
			offer(pack_op(OP_INSERT, 10'(n * 71), 4'(n)));
		offer(pack_op(OP_INSERT, 10'd3, 4'd15));
		offer(pack_op(OP_REMOVE, 10'd0, 4'd15));
		offer(pack_op(OP_READ, 10'd0, 4'd15));

		filling = 1'b0;
		phase_left = 0;
		for (n = 0; n < RANDOM_OPS; n++) begin
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(40, 90);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			if (r < 4)
				op = OP_NONE;
			else if (r < 16)
				op = OP_READ;
			else if (r < (filling ? 85 : 30))
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			r = $urandom_range(0, 99);
			if (r < 8)
				id = 10'($urandom_range(999, 1023));
			else if (r < 33)
				id = 10'($urandom_range(0, 7) * 100);
			else if (r < 38)
				id = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd998;
			else
				id = 10'($urandom_range(0, 998));
			if (op == OP_REMOVE && !filling && $urandom_range(0, 4) < 3)
				pos = 4'($urandom_range(0, 3));
			else
				pos = 4'($urandom_range(0, 15));
			offer(pack_op(op, id, pos));
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** sorted_slot_list_top: PASSED **");
		else
			$display("** sorted_slot_list_top: FAILED **");
		$finish;
	end

	initial begin : receiver
		int mode;
		int span;
		int rx_cycles;
		bit held_off;
		rx_cycles = 0;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// one long hold-off so the result register backs up into the input
			if (!held_off && rx_cycles >= 400) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (250) @(posedge clk);
				rx_cycles += 250;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (int k = 0; k < span; k++) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
				@(posedge clk);
				rx_cycles++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** sorted_slot_list_top: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end
endmodule
